// ----- rtl/boolean_cover_error_counter_top_assert.svh -----
// Assertion macros for the boolean cover error counter.
// Used by the modules under rtl/ that carry concurrent checks; no dependencies.
`ifndef BOOLEAN_COVER_ERROR_COUNTER_TOP_ASSERT_SVH
`define BOOLEAN_COVER_ERROR_COUNTER_TOP_ASSERT_SVH

// Check that holds at every clock edge outside reset
`define BCEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on the cycle after a trigger condition
`define BCEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bcec_pkg.sv -----
// Shared types, constants and functions for the boolean cover error counter.
// No dependencies; used by every module under rtl/.
package bcec_pkg;

  // Parameter defaults
  localparam int MAX_COLUMNS_DEF    = 64;
  localparam int MAX_BASIS_ROWS_DEF = 32;

  // Field widths
  localparam int COL_FIELD_W = 64;
  localparam int ROW_FIELD_W = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_FIELD_W = 7;
  localparam int TOT_W       = 32;
  localparam int ACOL_W      = 7;
  localparam int AROW_W      = 6;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register reset values
  localparam logic [ACOL_W-1:0] ACOL_RESET = 7'd64;
  localparam logic [AROW_W-1:0] AROW_RESET = 6'd32;

  // Input word layout
  localparam int S_TDATA_W   = 168;
  localparam int S_IDX_LSB   = 0;
  localparam int S_BASIS_LSB = 5;
  localparam int S_USAGE_LSB = 69;
  localparam int S_DATA_LSB  = 101;

  // Output word layout
  localparam int M_TDATA_W    = 232;
  localparam int M_COVER_LSB  = 0;
  localparam int M_ROWMIS_LSB = 64;
  localparam int M_TOT_LSB    = 71;

  // Running totals, in output order
  localparam int NUM_TOT      = 5;
  localparam int TOT_MISMATCH = 0;
  localparam int TOT_DATA     = 1;
  localparam int TOT_COVER    = 2;
  localparam int TOT_UNDER    = 3;
  localparam int TOT_OVER     = 4;

  typedef enum logic {
    REG_ACTIVE_COLUMNS    = 1'b0,
    REG_ACTIVE_BASIS_ROWS = 1'b1
  } reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  // Control that travels alongside each word in the chain
  typedef struct packed {
    logic valid;
    cmd_e cmd;
    logic last;
  } ctl_t;

  // Population count as a balanced adder tree, six levels
  function automatic logic [6:0] popcount64(logic [63:0] v);
    logic [6:0] acc [64];
    for (int i = 0; i < 64; i++) begin
      acc[i] = 7'(v[i]);
    end
    for (int s = 1; s < 64; s = s * 2) begin
      for (int i = 0; i < 64; i = i + 2 * s) begin
        acc[i] = acc[i] + acc[i + s];
      end
    end
    return acc[0];
  endfunction

endpackage

// ----- rtl/bcec_cell.sv -----
// One cell of the basis chain: holds one basis row and ORs it into the cover.
// Depends on bcec_pkg.
module bcec_cell #(
  parameter int COLS    = bcec_pkg::MAX_COLUMNS_DEF,
  parameter int ROWS    = bcec_pkg::MAX_BASIS_ROWS_DEF,
  parameter int ROW_IDX = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  bcec_pkg::ctl_t               ctl_i,
  input  logic [bcec_pkg::IDX_W-1:0]   idx_i,
  input  logic [COLS-1:0]              basis_i,
  input  logic [ROWS-1:0]              usage_i,
  input  logic [COLS-1:0]              data_i,
  input  logic [COLS-1:0]              cover_i,
  output bcec_pkg::ctl_t               ctl_o,
  output logic [bcec_pkg::IDX_W-1:0]   idx_o,
  output logic [COLS-1:0]              basis_o,
  output logic [ROWS-1:0]              usage_o,
  output logic [COLS-1:0]              data_o,
  output logic [COLS-1:0]              cover_o
);

  localparam int IW = bcec_pkg::IDX_W;

  logic [COLS-1:0]   row_q;
  logic              load_hit;
  logic              use_row;
  bcec_pkg::ctl_t    ctl_q;
  logic [IW-1:0]     idx_q;
  logic [COLS-1:0]   basis_q;
  logic [ROWS-1:0]   usage_q;
  logic [COLS-1:0]   data_q;
  logic [COLS-1:0]   cover_q;
  logic [COLS-1:0]   cover_d;

  // A load word writes this row as it passes
  assign load_hit = adv_i && ctl_i.valid && (ctl_i.cmd == bcec_pkg::CMD_LOAD)
                    && (idx_i == IW'(ROW_IDX));
  assign use_row  = (ctl_i.cmd == bcec_pkg::CMD_EVAL) && usage_i[ROW_IDX];
  assign cover_d  = use_row ? (cover_i | row_q) : cover_i;

  // Basis row storage, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      row_q <= basis_i;
    end
  end

  // Control stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Payload stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q   <= idx_i;
      basis_q <= basis_i;
      usage_q <= usage_i;
      data_q  <= data_i;
      cover_q <= cover_d;
    end
  end

  assign ctl_o   = ctl_q;
  assign idx_o   = idx_q;
  assign basis_o = basis_q;
  assign usage_o = usage_q;
  assign data_o  = data_q;
  assign cover_o = cover_q;

endmodule

// ----- rtl/bcec_tally.sv -----
// Count stage and saturating accumulators behind the basis chain.
// Depends on bcec_pkg and the assertion macro header.
`include "boolean_cover_error_counter_top_assert.svh"

module bcec_tally #(
  parameter int COLS = bcec_pkg::MAX_COLUMNS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  bcec_pkg::ctl_t              ctl_i,
  input  logic [COLS-1:0]             cover_i,
  input  logic [COLS-1:0]             data_i,
  input  logic [COLS-1:0]             col_mask_i,
  output logic                        valid_o,
  output logic                        final_o,
  output logic [COLS-1:0]             cover_o,
  output logic [$clog2(COLS+1)-1:0]   row_mis_o,
  output logic [bcec_pkg::TOT_W-1:0]  totals_o [bcec_pkg::NUM_TOT]
);

  localparam int CNT_W = $clog2(COLS + 1);
  localparam int TW    = bcec_pkg::TOT_W;
  localparam int NT    = bcec_pkg::NUM_TOT;

  logic [COLS-1:0]  cover_m;
  logic [COLS-1:0]  cnt_src [NT];
  logic [CNT_W-1:0] cnt_d [NT];

  logic             s1_valid_q;
  logic             s1_last_q;
  logic [COLS-1:0]  s1_cover_q;
  logic [CNT_W-1:0] s1_cnt_q [NT];

  logic [TW-1:0]    sum_q [NT];
  logic [TW-1:0]    sum_sat [NT];
  logic [TW:0]      sum_ext [NT];

  logic             out_valid_q;
  logic             out_final_q;
  logic [COLS-1:0]  out_cover_q;
  logic [CNT_W-1:0] out_mis_q;
  logic [TW-1:0]    out_tot_q [NT];

  // Column masking and per-row counts
  always_comb begin
    cover_m = cover_i & col_mask_i;
    cnt_src[bcec_pkg::TOT_MISMATCH] = cover_m ^ data_i;
    cnt_src[bcec_pkg::TOT_DATA]     = data_i;
    cnt_src[bcec_pkg::TOT_COVER]    = cover_m;
    cnt_src[bcec_pkg::TOT_UNDER]    = data_i & ~cover_m;
    cnt_src[bcec_pkg::TOT_OVER]     = cover_m & ~data_i;
    for (int t = 0; t < NT; t++) begin
      cnt_d[t] = CNT_W'(bcec_pkg::popcount64(64'(cnt_src[t])));
    end
  end

  // Count stage, evaluate words only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= ctl_i.valid && (ctl_i.cmd == bcec_pkg::CMD_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_last_q  <= ctl_i.last;
      s1_cover_q <= cover_m;
      s1_cnt_q   <= cnt_d;
    end
  end

  // Saturating add of this row into each total
  always_comb begin
    for (int t = 0; t < NT; t++) begin
      sum_ext[t] = {1'b0, sum_q[t]} + (TW + 1)'(s1_cnt_q[t]);
      sum_sat[t] = sum_ext[t][TW] ? {TW{1'b1}} : sum_ext[t][TW-1:0];
    end
  end

  // Accumulators; cleared after the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NT; t++) begin
        sum_q[t] <= '0;
      end
    end else if (adv_i && s1_valid_q) begin
      for (int t = 0; t < NT; t++) begin
        sum_q[t] <= s1_last_q ? '0 : sum_sat[t];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_valid_q) begin
      out_final_q <= s1_last_q;
      out_cover_q <= s1_cover_q;
      out_mis_q   <= s1_cnt_q[bcec_pkg::TOT_MISMATCH];
      out_tot_q   <= sum_sat;
    end
  end

  assign valid_o   = out_valid_q;
  assign final_o   = out_final_q;
  assign cover_o   = out_cover_q;
  assign row_mis_o = out_mis_q;
  assign totals_o  = out_tot_q;

  // Mismatches split exactly into uncovered ones and overcovered zeros
  `BCEC_ASSERT(a_mis_split, s1_valid_q |-> (s1_cnt_q[bcec_pkg::TOT_MISMATCH] == CNT_W'(s1_cnt_q[bcec_pkg::TOT_UNDER] + s1_cnt_q[bcec_pkg::TOT_OVER])), "row mismatch count differs from uncovered plus overcovered")
  // Totals restart from zero after a last row
  `BCEC_ASSERT_NEXT(a_clear_last, adv_i && s1_valid_q && s1_last_q, (sum_q[bcec_pkg::TOT_MISMATCH] == '0) && (sum_q[bcec_pkg::TOT_DATA] == '0) && (sum_q[bcec_pkg::TOT_COVER] == '0) && (sum_q[bcec_pkg::TOT_UNDER] == '0) && (sum_q[bcec_pkg::TOT_OVER] == '0), "totals not cleared after last row")

endmodule

// ----- rtl/boolean_cover_error_counter_top.sv -----
// Top level of the boolean cover error counter: stream ports, APB registers,
// basis cell chain and tally stage. Depends on bcec_pkg, bcec_cell, bcec_tally.
`include "boolean_cover_error_counter_top_assert.svh"

// Takes one input word per clock cycle unless the output stalls. Each input
// word passes a chain of MAX_BASIS_ROWS cells, one per basis row, then a count
// stage and the accumulator/output register. A load word (tuser = 0) writes
// its basis row as it passes the matching cell and gives no result; an evaluate
// word (tuser = 1) gives one result word with the cover row, its mismatch count
// and the saturating running totals. tlast on input marks the last data row:
// its result carries tlast and the totals are cleared after it. A stalled
// output holds the whole chain. Basis rows read before they are loaded give
// undefined cover bits. Registers: active_columns at 0x0, active_basis_rows
// at 0x4; write them only while no word is in flight.
module boolean_cover_error_counter_top #(
  parameter int MAX_COLUMNS    = bcec_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_BASIS_ROWS = bcec_pkg::MAX_BASIS_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // basis_index[4:0], basis_bits[68:5], usage_bits[100:69], data_bits[164:101], zero pad
  input  logic [bcec_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cover_bits[63:0], row_mismatches[70:64], total_mismatches[102:71],
  // data_ones[134:103], cover_ones[166:135], uncovered_ones[198:167],
  // overcovered_zeros[230:199], zero pad
  output logic [bcec_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast,
  // Register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bcec_pkg::PADDR_W-1:0]    paddr,
  input  logic [bcec_pkg::PDATA_W-1:0]    pwdata,
  output logic [bcec_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int COLS  = MAX_COLUMNS;
  localparam int ROWS  = MAX_BASIS_ROWS;
  localparam int CNT_W = $clog2(COLS + 1);
  localparam int IW    = bcec_pkg::IDX_W;
  localparam int TW    = bcec_pkg::TOT_W;
  localparam int NT    = bcec_pkg::NUM_TOT;

  logic [bcec_pkg::ACOL_W-1:0] act_cols_q;
  logic [bcec_pkg::AROW_W-1:0] act_rows_q;
  logic                        cfg_wr;
  bcec_pkg::reg_e              reg_sel;

  logic [COLS-1:0] col_mask;
  logic [ROWS-1:0] row_mask;
  logic            adv;

  bcec_pkg::ctl_t  ctl_c   [ROWS+1];
  logic [IW-1:0]   idx_c   [ROWS+1];
  logic [COLS-1:0] basis_c [ROWS+1];
  logic [ROWS-1:0] usage_c [ROWS+1];
  logic [COLS-1:0] data_c  [ROWS+1];
  logic [COLS-1:0] cover_c [ROWS+1];

  logic             out_valid;
  logic             out_final;
  logic [COLS-1:0]  out_cover;
  logic [CNT_W-1:0] out_mis;
  logic [TW-1:0]    out_tot [NT];

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = bcec_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cols_q <= bcec_pkg::ACOL_RESET;
      act_rows_q <= bcec_pkg::AROW_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        bcec_pkg::REG_ACTIVE_COLUMNS:    act_cols_q <= pwdata[bcec_pkg::ACOL_W-1:0];
        bcec_pkg::REG_ACTIVE_BASIS_ROWS: act_rows_q <= pwdata[bcec_pkg::AROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bcec_pkg::REG_ACTIVE_COLUMNS:    prdata = bcec_pkg::PDATA_W'(act_cols_q);
      bcec_pkg::REG_ACTIVE_BASIS_ROWS: prdata = bcec_pkg::PDATA_W'(act_rows_q);
      default:                         prdata = '0;
    endcase
  end

  // Active column and basis row masks
  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      col_mask[j] = act_cols_q > bcec_pkg::ACOL_W'(j);
    end
    for (int k = 0; k < ROWS; k++) begin
      row_mask[k] = act_rows_q > bcec_pkg::AROW_W'(k);
    end
  end

  // Whole pipeline moves unless a result waits
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Chain entry
  always_comb begin
    ctl_c[0].valid = s_axis_tvalid;
    ctl_c[0].cmd   = bcec_pkg::cmd_e'(s_axis_tuser);
    ctl_c[0].last  = s_axis_tlast;
    idx_c[0]   = s_axis_tdata[bcec_pkg::S_IDX_LSB +: IW];
    basis_c[0] = s_axis_tdata[bcec_pkg::S_BASIS_LSB +: COLS];
    usage_c[0] = s_axis_tdata[bcec_pkg::S_USAGE_LSB +: ROWS] & row_mask;
    data_c[0]  = s_axis_tdata[bcec_pkg::S_DATA_LSB +: COLS] & col_mask;
    cover_c[0] = '0;
  end

  // Basis cell chain
  for (genvar k = 0; k < ROWS; k++) begin : g_cell
    bcec_cell #(
      .COLS    (COLS),
      .ROWS    (ROWS),
      .ROW_IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .ctl_i   (ctl_c[k]),
      .idx_i   (idx_c[k]),
      .basis_i (basis_c[k]),
      .usage_i (usage_c[k]),
      .data_i  (data_c[k]),
      .cover_i (cover_c[k]),
      .ctl_o   (ctl_c[k+1]),
      .idx_o   (idx_c[k+1]),
      .basis_o (basis_c[k+1]),
      .usage_o (usage_c[k+1]),
      .data_o  (data_c[k+1]),
      .cover_o (cover_c[k+1])
    );
  end

  // Counts and totals
  bcec_tally #(
    .COLS (COLS)
  ) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .ctl_i      (ctl_c[ROWS]),
    .cover_i    (cover_c[ROWS]),
    .data_i     (data_c[ROWS]),
    .col_mask_i (col_mask),
    .valid_o    (out_valid),
    .final_o    (out_final),
    .cover_o    (out_cover),
    .row_mis_o  (out_mis),
    .totals_o   (out_tot)
  );

  // Output word packing
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[bcec_pkg::M_COVER_LSB +: bcec_pkg::COL_FIELD_W] =
      bcec_pkg::COL_FIELD_W'(out_cover);
    m_axis_tdata[bcec_pkg::M_ROWMIS_LSB +: bcec_pkg::CNT_FIELD_W] =
      bcec_pkg::CNT_FIELD_W'(out_mis);
    for (int t = 0; t < NT; t++) begin
      m_axis_tdata[bcec_pkg::M_TOT_LSB + t * TW +: TW] = out_tot[t];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_final;

  // Row mismatch count never exceeds the active columns
  `BCEC_ASSERT(a_mis_bound, out_valid |-> (bcec_pkg::ACOL_W'(out_mis) <= act_cols_q), "row mismatches exceed active columns")
  // Cover has no bits outside the active columns
  `BCEC_ASSERT(a_cover_mask, out_valid |-> ((out_cover & ~col_mask) == '0), "cover bit set outside active columns")

endmodule
